[design/msrc_pkg.sv]
// ----------------------------------------------------------------------------
// msrc_pkg
// Shared types and constants for the Modbus sensor response checker.
// ----------------------------------------------------------------------------
package msrc_pkg;

   // frame geometry
   localparam int DATA_BYTES = 14;
   localparam int DATA_IDX_W = $clog2(DATA_BYTES);
   localparam int POS_W      = 5;

   localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(3);
   localparam logic [POS_W-1:0] CRC_POS   = POS_W'(DATA_BYTES + 3);
   localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(DATA_BYTES + 5);
   localparam logic [POS_W-1:0] POS_SAT   = POS_W'(DATA_BYTES + 6);

   // header byte positions
   localparam logic [POS_W-1:0] POS_ADDRESS  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_FUNCTION = POS_W'(1);
   localparam logic [POS_W-1:0] POS_COUNT    = POS_W'(2);

   localparam logic [7:0] BYTE_COUNT = 8'(DATA_BYTES);

   // CRC-16/Modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_LENGTH   = 3'd1;
   localparam logic [2:0] ERR_ADDRESS  = 3'd2;
   localparam logic [2:0] ERR_FUNCTION = 3'd3;
   localparam logic [2:0] ERR_COUNT    = 3'd4;
   localparam logic [2:0] ERR_CRC      = 3'd5;

   // configuration register indexes
   localparam logic CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic CSR_FUNCTION_CODE = 1'b1;

   // one result word
   typedef struct packed {
      logic               frame_ok;
      logic [2:0]         error_code;
      logic [31:0]        light_raw;
      logic signed [15:0] temperature_raw;
      logic [31:0]        pressure_raw;
      logic [15:0]        humidity_raw;
      logic [15:0]        altitude_m;
   } rsp_type;

endpackage

[design/modbus_sensor_response_checker.sv]
// ----------------------------------------------------------------------------
// modbus_sensor_response_checker
// Checks a Modbus RTU read-holding response, one byte per word, and gives
// one result word with error code and raw sensor fields per frame.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          word
//  req_      in         valid / stall      rx_byte, frame_end
//  rsp_      out        valid / stall      frame_ok, error_code, sensor fields
//  csr_      in         valid / ready      index, wdata
//
// One byte per cycle sustained while no result is stalled. A byte is held in
// the input register, then the frame tracker (CRC over eight unrolled steps)
// updates and the result register loads on the last byte: rsp_valid rises
// once the last byte has passed from the input register to the result register.
// Reset is synchronous and clears both valids and the frame state.
// req_stall is high while the input register holds a byte and the result
// register holds a word that is stalled; any held byte waits, last or not.
// ----------------------------------------------------------------------------
module modbus_sensor_response_checker
   import msrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input bytes
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_end,
   // results
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_ok,
   output logic [2:0]         rsp_error_code,
   output logic [31:0]        rsp_light_raw,
   output logic signed [15:0] rsp_temperature_raw,
   output logic [31:0]        rsp_pressure_raw,
   output logic [15:0]        rsp_humidity_raw,
   output logic [15:0]        rsp_altitude_m,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_end_ff;
   logic       advance, step_en;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, result;
   logic [7:0] slave_address_ff, function_code_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'd1;
         function_code_ff <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS: slave_address_ff <= csr_wdata;
            CSR_FUNCTION_CODE: function_code_ff <= csr_wdata;
         endcase
      end
   end

   // pipeline flow
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_en   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance ? (step_en && s1_end_ff) : rsp_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_rx_byte;
         s1_end_ff  <= req_frame_end;
      end
   end

   msrc_frame_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .rx_byte       (s1_byte_ff),
      .frame_end     (s1_end_ff),
      .slave_address (slave_address_ff),
      .function_code (function_code_ff),
      .result        (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && s1_end_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_ok        = rsp_ff.frame_ok;
   assign rsp_error_code      = rsp_ff.error_code;
   assign rsp_light_raw       = rsp_ff.light_raw;
   assign rsp_temperature_raw = rsp_ff.temperature_raw;
   assign rsp_pressure_raw    = rsp_ff.pressure_raw;
   assign rsp_humidity_raw    = rsp_ff.humidity_raw;
   assign rsp_altitude_m      = rsp_ff.altitude_m;

endmodule

[design/msrc_crc_byte.sv]
// ----------------------------------------------------------------------------
// msrc_crc_byte
// One byte of CRC-16/Modbus, eight reflected shift steps unrolled.
// ----------------------------------------------------------------------------
module msrc_crc_byte
   import msrc_pkg::*;
(
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_out
);

   // reflected LFSR, LSB first
   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

[design/msrc_frame_tracker.sv]
// ----------------------------------------------------------------------------
// msrc_frame_tracker
// Per-frame state: CRC, byte count, header check and data byte store.
// Builds the result word on the last byte of a frame.
// ----------------------------------------------------------------------------
module msrc_frame_tracker
   import msrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] rx_byte,
   input  logic       frame_end,
   input  logic [7:0] slave_address,
   input  logic [7:0] function_code,
   output rsp_type    result
);

   logic [15:0]      crc_ff, crc_in, crc_upd;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       hdr_ff, hdr_in;
   logic [7:0]       crc_low_ff;
   logic [7:0]       data_ff [DATA_BYTES];
   logic [POS_W-1:0] data_off;
   logic [DATA_IDX_W-1:0] data_idx;
   logic             in_data;
   logic [2:0]       err;

   msrc_crc_byte u_crc (
      .crc_in    (crc_ff),
      .data_byte (rx_byte),
      .crc_out   (crc_upd)
   );

   assign data_off = pos_ff - HDR_BYTES;
   assign data_idx = data_off[DATA_IDX_W-1:0];
   assign in_data  = (pos_ff >= HDR_BYTES) && (pos_ff < CRC_POS);

   // next frame state for this byte
   always_comb begin
      crc_in = (pos_ff < CRC_POS) ? crc_upd : crc_ff;
      pos_in = (pos_ff < POS_SAT) ? pos_ff + POS_W'(1) : pos_ff;
      hdr_in = hdr_ff;
      if (hdr_ff == ERR_NONE) begin
         if (pos_ff == POS_ADDRESS && rx_byte != slave_address) begin
            hdr_in = ERR_ADDRESS;
         end else if (pos_ff == POS_FUNCTION && rx_byte != function_code) begin
            hdr_in = ERR_FUNCTION;
         end else if (pos_ff == POS_COUNT && rx_byte != BYTE_COUNT) begin
            hdr_in = ERR_COUNT;
         end
      end
   end

   // checks in priority order; CRC high byte is the current byte
   always_comb begin
      priority if (pos_in != FRAME_LEN) begin
         err = ERR_LENGTH;
      end else if (hdr_in != ERR_NONE) begin
         err = hdr_in;
      end else if ({rx_byte, crc_low_ff} != crc_in) begin
         err = ERR_CRC;
      end else begin
         err = ERR_NONE;
      end
   end

   // result word, value fields zero on a failed frame
   always_comb begin
      result            = '0;
      result.frame_ok   = (err == ERR_NONE);
      result.error_code = err;
      if (err == ERR_NONE) begin
         result.light_raw       = {data_ff[0], data_ff[1], data_ff[2], data_ff[3]};
         result.temperature_raw = signed'({data_ff[4], data_ff[5]});
         result.pressure_raw    = {data_ff[6], data_ff[7], data_ff[8], data_ff[9]};
         result.humidity_raw    = {data_ff[10], data_ff[11]};
         result.altitude_m      = {data_ff[12], data_ff[13]};
      end
   end

   // frame control state, restarts after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         pos_ff <= '0;
         hdr_ff <= ERR_NONE;
      end else if (step_en) begin
         if (frame_end) begin
            crc_ff <= CRC_INIT;
            pos_ff <= '0;
            hdr_ff <= ERR_NONE;
         end else begin
            crc_ff <= crc_in;
            pos_ff <= pos_in;
            hdr_ff <= hdr_in;
         end
      end
   end

   // data and CRC low byte store
   always_ff @(posedge clock) begin
      if (step_en && in_data) begin
         data_ff[data_idx] <= rx_byte;
      end
      if (step_en && pos_ff == CRC_POS) begin
         crc_low_ff <= rx_byte;
      end
   end

endmodule
